// File: hdl/pvi_pkg.sv
// ----------------------------------------------------------------------------
// pvi_pkg
// Shared constants, register codes and helper functions for the periodic
// trilinear voxel interpolator.
// ----------------------------------------------------------------------------
package pvi_pkg;

   // grid limits per axis
   localparam int MAX_GRID_X = 32;
   localparam int MAX_GRID_Y = 32;
   localparam int MAX_GRID_Z = 32;
   localparam int STORE_DEPTH = MAX_GRID_X * MAX_GRID_Y * MAX_GRID_Z;
   localparam int ADDR_W = $clog2(STORE_DEPTH);

   // field widths
   localparam int DATA_W = 32;
   localparam int VOX_IDX_W = 5;
   localparam int GRID_W = 6;
   localparam int INV_W = 24;
   localparam int FRAC_W = 16;

   // scaled coordinate: signed point times unsigned inverse cell size
   localparam int PROD_W = DATA_W + INV_W + 1;

   // configuration port
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = INV_W;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_Z = 3'd5;

   localparam logic [GRID_W-1:0] GRID_RESET = 6'd32;
   localparam logic [INV_W-1:0] INV_RESET = 24'd65536;

   // operation codes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // pipeline stage count: product, three modulo stages, corner index,
   // memory read, z blend, y blend, x blend
   localparam int NUM_STAGES = 9;
   localparam int AXIS_STAGES = 5;

   typedef logic [GRID_W-1:0] grid_type;
   typedef logic [FRAC_W-1:0] weight_type;
   typedef logic signed [DATA_W-1:0] sample_type;

   // one step of restoring remainder: (2r + b) mod n, with r < n
   function automatic grid_type mod_step(input grid_type r, input logic b,
                                         input grid_type n);
      logic [GRID_W:0] t;
      t = {r, b};
      if (t >= {1'b0, n}) begin
         t = t - {1'b0, n};
      end
      return t[GRID_W-1:0];
   endfunction

   // effective grid size: zero acts as one, large values clamp to the max
   function automatic grid_type eff_size(input grid_type g, input int max_n);
      grid_type r;
      if (g == '0) begin
         r = GRID_W'(1);
      end else if (int'(g) > max_n) begin
         r = GRID_W'(max_n);
      end else begin
         r = g;
      end
      return r;
   endfunction

   // linear address of voxel (i, j, k)
   function automatic logic [ADDR_W-1:0] voxel_addr(input grid_type i,
                                                    input grid_type j,
                                                    input grid_type k);
      int a;
      a = (int'(i) * MAX_GRID_Y + int'(j)) * MAX_GRID_Z + int'(k);
      return ADDR_W'(a);
   endfunction

endpackage

// File: hdl/pvi_req_if.sv
// ----------------------------------------------------------------------------
// pvi_req_if
// Request channel: load and query beats with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pvi_req_if import pvi_pkg::*; ();
   logic valid;
   logic ready;
   logic operation;
   logic [VOX_IDX_W-1:0] voxel_i;
   logic [VOX_IDX_W-1:0] voxel_j;
   logic [VOX_IDX_W-1:0] voxel_k;
   logic signed [DATA_W-1:0] sample_value;
   logic signed [DATA_W-1:0] point_x;
   logic signed [DATA_W-1:0] point_y;
   logic signed [DATA_W-1:0] point_z;

   modport source(output valid, operation, voxel_i, voxel_j, voxel_k, sample_value,
                  point_x, point_y, point_z, input ready);
   modport sink(input valid, operation, voxel_i, voxel_j, voxel_k, sample_value,
                point_x, point_y, point_z, output ready);
endinterface

// File: hdl/pvi_rsp_if.sv
// ----------------------------------------------------------------------------
// pvi_rsp_if
// Response channel: one interpolated value per query beat.
// ----------------------------------------------------------------------------
interface pvi_rsp_if import pvi_pkg::*; ();
   logic valid;
   logic ready;
   logic signed [DATA_W-1:0] interp_value;

   modport source(output valid, interp_value, input ready);
   modport sink(input valid, interp_value, output ready);
endinterface

// File: hdl/pvi_ram.sv
// ----------------------------------------------------------------------------
// pvi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pvi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_enable,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;
endmodule

// File: hdl/pvi_axis.sv
// ----------------------------------------------------------------------------
// pvi_axis
// Per-axis coordinate pipeline: scale by inverse cell size, then reduce the
// integer part modulo the grid size over three stages, then form the low and
// high corner indices and the fractional weight.
// ----------------------------------------------------------------------------
module pvi_axis import pvi_pkg::*; (
   input  logic                     clock,
   input  logic [AXIS_STAGES-1:0]   adv,
   input  logic signed [DATA_W-1:0] point,
   input  logic [INV_W-1:0]         inv_cell,
   input  grid_type                 grid_n,
   output grid_type                 lo,
   output grid_type                 hi,
   output weight_type               weight
);
   // sign bit of the integer part of the scaled coordinate
   localparam int SIGN_BIT = 2 * FRAC_W + INV_W - 1;

   logic signed [PROD_W-1:0] prod_ff, prod_in;

   grid_type   rem1_ff, rem1_in;
   logic [14:0] rest1_ff;
   weight_type w1_ff;

   grid_type   rem2_ff, rem2_in;
   logic [6:0] rest2_ff;
   weight_type w2_ff;

   grid_type   rem3_ff, rem3_in;
   weight_type w3_ff;

   grid_type   lo_ff, hi_ff, hi_in;
   weight_type w4_ff;

   // scale
   assign prod_in = PROD_W'(point) * PROD_W'($signed({1'b0, inv_cell}));

   // remainder of the upper integer bits; a negative value starts at -1
   always_comb begin
      rem1_in = prod_ff[SIGN_BIT] ? grid_type'(grid_n - GRID_W'(1)) : '0;
      for (int s = 0; s < 8; s++) begin
         rem1_in = mod_step(rem1_in, prod_ff[SIGN_BIT-1-s], grid_n);
      end
   end

   always_comb begin
      rem2_in = rem1_ff;
      for (int s = 0; s < 8; s++) begin
         rem2_in = mod_step(rem2_in, rest1_ff[14-s], grid_n);
      end
   end

   always_comb begin
      rem3_in = rem2_ff;
      for (int s = 0; s < 7; s++) begin
         rem3_in = mod_step(rem3_in, rest2_ff[6-s], grid_n);
      end
   end

   // periodic wrap of the high corner
   assign hi_in = (GRID_W'(rem3_ff + GRID_W'(1)) == grid_n) ? '0
                  : GRID_W'(rem3_ff + GRID_W'(1));

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         prod_ff <= prod_in;
      end
      if (adv[1]) begin
         rem1_ff  <= rem1_in;
         rest1_ff <= prod_ff[SIGN_BIT-9 -: 15];
         w1_ff    <= prod_ff[2*FRAC_W-1 -: FRAC_W];
      end
      if (adv[2]) begin
         rem2_ff  <= rem2_in;
         rest2_ff <= rest1_ff[6:0];
         w2_ff    <= w1_ff;
      end
      if (adv[3]) begin
         rem3_ff <= rem3_in;
         w3_ff   <= w2_ff;
      end
      if (adv[4]) begin
         lo_ff <= rem3_ff;
         hi_ff <= hi_in;
         w4_ff <= w3_ff;
      end
   end

   assign lo = lo_ff;
   assign hi = hi_ff;
   assign weight = w4_ff;
endmodule

// File: hdl/pvi_lerp.sv
// ----------------------------------------------------------------------------
// pvi_lerp
// One registered linear blend: round(a*(1-w) + b*w) in Q16.16, saturated.
// ----------------------------------------------------------------------------
module pvi_lerp import pvi_pkg::*; (
   input  logic       clock,
   input  logic       enable,
   input  sample_type a,
   input  sample_type b,
   input  weight_type weight,
   output sample_type q
);
   logic signed [FRAC_W+1:0] wa, wb;
   logic signed [DATA_W+FRAC_W+1:0] pa, pb;
   logic signed [DATA_W+FRAC_W+2:0] sum, shifted;
   sample_type q_ff, q_in;

   assign wa = $signed({1'b0, (FRAC_W+1)'((FRAC_W+1)'(1) << FRAC_W) - {1'b0, weight}});
   assign wb = $signed({2'b00, weight});
   assign pa = a * wa;
   assign pb = b * wb;
   assign sum = (DATA_W+FRAC_W+3)'(pa) + (DATA_W+FRAC_W+3)'(pb)
                + (DATA_W+FRAC_W+3)'(32768);
   assign shifted = sum >>> FRAC_W;

   // clamp to the Q16.16 range
   always_comb begin
      if (shifted > (DATA_W+FRAC_W+3)'(64'sd2147483647)) begin
         q_in = 32'sh7fffffff;
      end else if (shifted < -(DATA_W+FRAC_W+3)'(64'sd2147483648)) begin
         q_in = 32'sh80000000;
      end else begin
         q_in = DATA_W'(shifted);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;
endmodule

// File: hdl/periodic_trilinear_voxel_interp_top.sv
// ----------------------------------------------------------------------------
// periodic_trilinear_voxel_interp_top
// Voxel store with periodic trilinear interpolation of Q16.16 samples.
// ----------------------------------------------------------------------------
// A beat enters every cycle unless a response stall holds the input. A query
// passes one stage that scales the point, three stages that reduce the cell
// index modulo the grid size, one that forms the corner addresses, one that
// reads the eight corners from eight replicated voxel memories (one read port
// each, all written by every load), and three that blend along z, y and x.
// Loads write the store in the corner-address stage and give no result; a
// later query sees them. Response stalls propagate back through the advance
// chain in the same cycle, so empty stages still fill. The store has no reset;
// query only written voxels. The user must write grid sizes and inverse cell
// sizes through the csr port while no beat is in flight; no logic enforces it.
module periodic_trilinear_voxel_interp_top import pvi_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   pvi_req_if.sink               req_bus,
   pvi_rsp_if.source             rsp_bus
);
   // configuration registers
   grid_type          grid_x_ff, grid_y_ff, grid_z_ff;
   logic [INV_W-1:0]  inv_x_ff, inv_y_ff, inv_z_ff;
   grid_type          nx, ny, nz;

   // pipeline control
   logic [NUM_STAGES-1:0] v_ff, v_in, adv;

   // load payload travels through the axis stages
   logic                 op_ff   [AXIS_STAGES];
   logic [VOX_IDX_W-1:0] li_ff   [AXIS_STAGES];
   logic [VOX_IDX_W-1:0] lj_ff   [AXIS_STAGES];
   logic [VOX_IDX_W-1:0] lk_ff   [AXIS_STAGES];
   sample_type           ldat_ff [AXIS_STAGES];

   grid_type   xlo, xhi, ylo, yhi, zlo, zhi;
   weight_type wx4, wy4, wz4;
   weight_type wx5_ff, wy5_ff, wz5_ff, wx6_ff, wy6_ff, wx7_ff;

   logic              store_we;
   logic [ADDR_W-1:0] store_waddr;
   sample_type        corner [8];
   sample_type        zb [4];
   sample_type        yb [2];
   sample_type        result;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_x_ff <= GRID_RESET;
         grid_y_ff <= GRID_RESET;
         grid_z_ff <= GRID_RESET;
         inv_x_ff  <= INV_RESET;
         inv_y_ff  <= INV_RESET;
         inv_z_ff  <= INV_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_GRID_X: grid_x_ff <= csr_write_data[GRID_W-1:0];
            CSR_GRID_Y: grid_y_ff <= csr_write_data[GRID_W-1:0];
            CSR_GRID_Z: grid_z_ff <= csr_write_data[GRID_W-1:0];
            CSR_INV_X:  inv_x_ff  <= csr_write_data;
            CSR_INV_Y:  inv_y_ff  <= csr_write_data;
            CSR_INV_Z:  inv_z_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign nx = eff_size(grid_x_ff, MAX_GRID_X);
   assign ny = eff_size(grid_y_ff, MAX_GRID_Y);
   assign nz = eff_size(grid_z_ff, MAX_GRID_Z);

   // stage advance: a stage loads when it is empty or its successor loads
   always_comb begin
      adv[NUM_STAGES-1] = !v_ff[NUM_STAGES-1] || rsp_bus.ready;
      for (int s = NUM_STAGES - 2; s >= 0; s--) begin
         adv[s] = !v_ff[s] || adv[s+1];
      end
   end

   // valid bits; loads leave the pipe after the store write
   always_comb begin
      v_in[0] = adv[0] ? req_bus.valid : v_ff[0];
      for (int s = 1; s < NUM_STAGES; s++) begin
         v_in[s] = adv[s] ? v_ff[s-1] : v_ff[s];
      end
      if (adv[AXIS_STAGES]) begin
         v_in[AXIS_STAGES] = v_ff[AXIS_STAGES-1]
                             && (op_ff[AXIS_STAGES-1] == OP_QUERY);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // load payload registers
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         op_ff[0]   <= req_bus.operation;
         li_ff[0]   <= req_bus.voxel_i;
         lj_ff[0]   <= req_bus.voxel_j;
         lk_ff[0]   <= req_bus.voxel_k;
         ldat_ff[0] <= req_bus.sample_value;
      end
      for (int s = 1; s < AXIS_STAGES; s++) begin
         if (adv[s]) begin
            op_ff[s]   <= op_ff[s-1];
            li_ff[s]   <= li_ff[s-1];
            lj_ff[s]   <= lj_ff[s-1];
            lk_ff[s]   <= lk_ff[s-1];
            ldat_ff[s] <= ldat_ff[s-1];
         end
      end
   end

   // per-axis index and weight pipelines
   pvi_axis u_axis_x (
      .clock(clock), .adv(adv[AXIS_STAGES-1:0]), .point(req_bus.point_x),
      .inv_cell(inv_x_ff), .grid_n(nx), .lo(xlo), .hi(xhi), .weight(wx4)
   );
   pvi_axis u_axis_y (
      .clock(clock), .adv(adv[AXIS_STAGES-1:0]), .point(req_bus.point_y),
      .inv_cell(inv_y_ff), .grid_n(ny), .lo(ylo), .hi(yhi), .weight(wy4)
   );
   pvi_axis u_axis_z (
      .clock(clock), .adv(adv[AXIS_STAGES-1:0]), .point(req_bus.point_z),
      .inv_cell(inv_z_ff), .grid_n(nz), .lo(zlo), .hi(zhi), .weight(wz4)
   );

   // load write into every replica
   assign store_we = v_ff[AXIS_STAGES-1] && (op_ff[AXIS_STAGES-1] == OP_LOAD)
                     && adv[AXIS_STAGES]
                     && (int'(li_ff[AXIS_STAGES-1]) < MAX_GRID_X)
                     && (int'(lj_ff[AXIS_STAGES-1]) < MAX_GRID_Y)
                     && (int'(lk_ff[AXIS_STAGES-1]) < MAX_GRID_Z);
   assign store_waddr = voxel_addr(GRID_W'(li_ff[AXIS_STAGES-1]),
                                   GRID_W'(lj_ff[AXIS_STAGES-1]),
                                   GRID_W'(lk_ff[AXIS_STAGES-1]));

   // corner c = {x, y, z} select bits, one replica per corner
   for (genvar c = 0; c < 8; c++) begin : g_corner
      logic [ADDR_W-1:0] raddr;
      logic [DATA_W-1:0] rdata;

      assign raddr = voxel_addr(c[2] ? xhi : xlo, c[1] ? yhi : ylo, c[0] ? zhi : zlo);

      pvi_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_ram (
         .clock(clock),
         .write_enable(store_we),
         .write_addr(store_waddr),
         .write_data(ldat_ff[AXIS_STAGES-1]),
         .read_enable(adv[AXIS_STAGES]),
         .read_addr(raddr),
         .read_data(rdata)
      );

      assign corner[c] = $signed(rdata);
   end

   // weights follow the blend stages
   always_ff @(posedge clock) begin
      if (adv[5]) begin
         wx5_ff <= wx4;
         wy5_ff <= wy4;
         wz5_ff <= wz4;
      end
      if (adv[6]) begin
         wx6_ff <= wx5_ff;
         wy6_ff <= wy5_ff;
      end
      if (adv[7]) begin
         wx7_ff <= wx6_ff;
      end
   end

   // z blends
   for (genvar p = 0; p < 4; p++) begin : g_zblend
      pvi_lerp u_lerp (
         .clock(clock), .enable(adv[6]), .a(corner[2*p]), .b(corner[2*p+1]),
         .weight(wz5_ff), .q(zb[p])
      );
   end

   // y blends
   for (genvar p = 0; p < 2; p++) begin : g_yblend
      pvi_lerp u_lerp (
         .clock(clock), .enable(adv[7]), .a(zb[2*p]), .b(zb[2*p+1]),
         .weight(wy6_ff), .q(yb[p])
      );
   end

   // x blend into the output register
   pvi_lerp u_xblend (
      .clock(clock), .enable(adv[8]), .a(yb[0]), .b(yb[1]),
      .weight(wx7_ff), .q(result)
   );

   assign req_bus.ready = adv[0];
   assign rsp_bus.valid = v_ff[NUM_STAGES-1];
   assign rsp_bus.interp_value = result;

   // a load never reaches the read stage
   a_load_dropped: assert property (@(posedge clock) disable iff (reset)
      (v_ff[4] && op_ff[4] == OP_LOAD && adv[5]) |=> !v_ff[5])
      else $error("load beat entered the read stage");

   // low corner stays inside the active grid
   a_lo_in_range: assert property (@(posedge clock) disable iff (reset)
      (v_ff[4] && op_ff[4] == OP_QUERY) |-> (xlo < nx && ylo < ny && zlo < nz))
      else $error("corner index outside grid");

   // high corner is the periodic successor of the low corner on x and y
   a_hi_wraps: assert property (@(posedge clock) disable iff (reset)
      (v_ff[4] && op_ff[4] == OP_QUERY) |->
      ((xhi == GRID_W'(xlo + GRID_W'(1)) || xhi == '0) &&
       (yhi == GRID_W'(ylo + GRID_W'(1)) || yhi == '0)))
      else $error("high corner not a periodic successor");

   // a stalled result does not move
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |=> (rsp_bus.valid && $stable(result)))
      else $error("result changed while stalled");
endmodule
